@@ hw/rtl/pidfd_pkg.sv @@
// Shared widths, constants, types and saturation helpers for the PID controller.
package pidfd_pkg;

    localparam int DATA_W  = 32;
    localparam int TF_W    = 20;
    localparam int FRAC    = 16;
    localparam int DT_W    = 17;
    localparam int ACC_W   = 34;
    localparam int FILT_W  = 48;
    localparam int MA_W    = 48;
    localparam int MB_W    = 32;
    localparam int PW      = MA_W + MB_W;
    localparam int CNT_W   = 6;
    localparam int DVD_W   = DATA_W + TF_W;
    localparam int CFG_W   = 3;
    localparam int LIM_W   = 31;

    localparam logic [DT_W-1:0]  DT_MIN    = 17'd105;
    localparam logic [DT_W-1:0]  DT_MAX    = 17'd104858;
    localparam logic [MB_W-1:0]  ALPHA_NEW = 32'd19661;
    localparam logic [MB_W-1:0]  ALPHA_OLD = 32'd45875;
    localparam logic [CNT_W-1:0] N_GAIN    = 6'd32;
    localparam logic [CNT_W-1:0] N_DT      = 6'd18;
    localparam logic [CNT_W-1:0] N_ALPHA   = 6'd17;
    localparam logic [CNT_W-1:0] DIV_STEPS = 6'd52;

    localparam logic [CFG_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_GAIN_I   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_GAIN_D   = 3'd2;
    localparam logic [CFG_W-1:0] CFG_OUT_LIM  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_INT_LIM  = 3'd4;

    localparam logic OP_CLEAR = 1'b1;

    localparam logic [LIM_W-1:0] OUT_LIM_RST = 31'h7fffffff;
    localparam logic [LIM_W-1:0] INT_LIM_RST = 31'h3fffffff;

    typedef struct packed {
        logic                    start;
        logic                    accum;
        logic signed [MA_W-1:0]  a;
        logic signed [MB_W-1:0]  b;
        logic [CNT_W-1:0]        n;
    } t_mul_req;

    function automatic logic signed [DATA_W-1:0] sat_to_data(input logic signed [PW:0] v);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        hi = $signed({{(PW+1-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [FILT_W-1:0] sat_to_filt(input logic signed [PW:0] v);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        hi = $signed({{(PW+1-FILT_W){1'b0}}, 1'b0, {(FILT_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[FILT_W-1:0];
        end else if (v < lo) begin
            return lo[FILT_W-1:0];
        end
        return v[FILT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/pidfd_mul.sv @@
// Bit-serial signed shift-and-add multiplier with optional accumulation.
module pidfd_mul
    import pidfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mul_req              i_req,
    output logic                  o_done,
    output logic signed [PW-1:0]  o_prod
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [PW-1:0]  r_a;
    logic [MB_W-1:0]       r_b;
    logic signed [PW-1:0]  r_prod;
    logic                  w_last;

    assign w_last = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.n;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The last multiplier bit processed carries negative weight.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= PW'(i_req.a);
            r_b    <= i_req.b;
            r_prod <= i_req.accum ? r_prod : '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_prod <= w_last ? (r_prod - r_a) : (r_prod + r_a);
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

@@ hw/rtl/pidfd_div.sv @@
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module pidfd_div
    import pidfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DT_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [DVD_W-1:0]  o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DVD_W-1:0]    r_q;
    logic [DT_W-1:0]     r_rem;
    logic [DT_W-1:0]     r_dvs;
    logic [DT_W:0]       w_rem_sh;
    logic [DT_W:0]       w_diff;
    logic                w_ge;

    assign w_rem_sh = {r_rem, r_q[DVD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DT_W-1:0] : w_rem_sh[DT_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ hw/rtl/pid_filtered_derivative_antiwindup.sv @@
// Top level of the fixed-point PID controller with filtered derivative and anti-windup.
// A control step presents its result once the products below are done; a clear goes straight to the result.
// The shared bit-serial multiplier forms six products one after another, while the divider
// for the rate runs alongside them.
// One item is in work at a time: a new item is taken only after the last result is issued.
// Synchronous active-low reset loads register defaults and clears the controller state.
module pid_filtered_derivative_antiwindup
    import pidfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_op,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_measured,
    input  logic [TF_W-1:0]          i_step_time,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_drive,
    output logic                     o_saturated
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PREP = 10'b0000000010,
        S_P    = 10'b0000000100,
        S_EDT  = 10'b0000001000,
        S_I    = 10'b0000010000,
        S_DIVW = 10'b0000100000,
        S_F1   = 10'b0001000000,
        S_F2   = 10'b0010000000,
        S_D    = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    t_state                    r_state, n_state;
    logic signed [DATA_W-1:0]  r_gain_p, n_gain_p;
    logic signed [DATA_W-1:0]  r_gain_i, n_gain_i;
    logic signed [DATA_W-1:0]  r_gain_d, n_gain_d;
    logic [LIM_W-1:0]          r_out_lim, n_out_lim;
    logic [LIM_W-1:0]          r_int_lim, n_int_lim;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [DATA_W-1:0]  r_last, n_last;
    logic signed [FILT_W-1:0]  r_filt, n_filt;
    logic                      r_clr, n_clr;
    logic signed [DATA_W-1:0]  r_meas, n_meas;
    logic signed [DATA_W-1:0]  r_err, n_err;
    logic [DT_W-1:0]           r_dt, n_dt;
    logic                      r_neg, n_neg;
    logic signed [ACC_W-1:0]   r_edt, n_edt;
    logic signed [DATA_W-1:0]  r_p, n_p;
    logic signed [DATA_W-1:0]  r_i, n_i;
    logic signed [DATA_W-1:0]  r_d, n_d;
    logic                      r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0]  r_drive, n_drive;
    logic                      r_sat, n_sat;

    t_mul_req                  w_mul_req;
    logic                      w_mul_done;
    logic signed [PW-1:0]      w_prod;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [DVD_W-1:0]          w_quot;
    logic [DVD_W-1:0]          w_dividend;

    logic [DATA_W:0]           w_diff;
    logic [DATA_W:0]           w_delta;
    logic [DATA_W:0]           w_mag;
    logic signed [ACC_W-1:0]   w_edt;
    logic signed [ACC_W:0]     w_acc_sum;
    logic signed [ACC_W:0]     w_ilim;
    logic signed [ACC_W-1:0]   w_acc_cl;
    logic signed [FILT_W-1:0]  w_rate;
    logic signed [FILT_W-1:0]  w_filt;
    logic signed [DATA_W+1:0]  w_sum;
    logic signed [DATA_W+1:0]  w_olim;
    logic signed [DATA_W+1:0]  w_clamp;
    logic                      w_hi;
    logic                      w_lo;
    logic                      w_fin_go;

    pidfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pidfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_diff     = {i_target[DATA_W-1], i_target} - {i_measured[DATA_W-1], i_measured};
        w_delta    = {r_meas[DATA_W-1], r_meas} - {r_last[DATA_W-1], r_last};
        w_mag      = w_delta[DATA_W] ? (~w_delta + (DATA_W+1)'(1)) : w_delta;
        w_dividend = {w_mag[DATA_W-1:0], {TF_W{1'b0}}};

        w_edt     = ACC_W'(w_prod >>> TF_W);
        w_acc_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_edt);
        w_ilim    = $signed((ACC_W+1)'(r_int_lim));
        if (w_acc_sum > w_ilim) begin
            w_acc_cl = ACC_W'(w_ilim);
        end else if (w_acc_sum < -w_ilim) begin
            w_acc_cl = ACC_W'(-w_ilim);
        end else begin
            w_acc_cl = ACC_W'(w_acc_sum);
        end

        w_rate = r_neg ? -$signed(FILT_W'(w_quot)) : $signed(FILT_W'(w_quot));
        w_filt = sat_to_filt((PW+1)'(w_prod >>> FRAC));

        w_sum  = (DATA_W+2)'(r_p) + (DATA_W+2)'(r_i) + (DATA_W+2)'(r_d);
        w_olim = $signed((DATA_W+2)'(r_out_lim));
        w_hi   = (w_sum >= w_olim);
        w_lo   = (w_sum <= -w_olim);
        if (w_sum > w_olim) begin
            w_clamp = w_olim;
        end else if (w_sum < -w_olim) begin
            w_clamp = -w_olim;
        end else begin
            w_clamp = w_sum;
        end

        w_fin_go = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_state     = r_state;
        n_gain_p    = r_gain_p;
        n_gain_i    = r_gain_i;
        n_gain_d    = r_gain_d;
        n_out_lim   = r_out_lim;
        n_int_lim   = r_int_lim;
        n_acc       = r_acc;
        n_last      = r_last;
        n_filt      = r_filt;
        n_clr       = r_clr;
        n_meas      = r_meas;
        n_err       = r_err;
        n_dt        = r_dt;
        n_neg       = r_neg;
        n_edt       = r_edt;
        n_p         = r_p;
        n_i         = r_i;
        n_d         = r_d;
        n_drive     = r_drive;
        n_sat       = r_sat;
        n_out_valid = (r_out_valid && !i_out_ready);
        w_mul_req   = '0;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_clr  = (i_op == OP_CLEAR);
                    n_meas = i_measured;
                    if (w_diff[DATA_W] != w_diff[DATA_W-1]) begin
                        n_err = w_diff[DATA_W] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
                                               : $signed({1'b0, {(DATA_W-1){1'b1}}});
                    end else begin
                        n_err = $signed(w_diff[DATA_W-1:0]);
                    end
                    if (i_step_time < TF_W'(DT_MIN)) begin
                        n_dt = DT_MIN;
                    end else if (i_step_time > TF_W'(DT_MAX)) begin
                        n_dt = DT_MAX;
                    end else begin
                        n_dt = i_step_time[DT_W-1:0];
                    end
                    n_state = (i_op == OP_CLEAR) ? S_FIN : S_PREP;
                end
            end
            S_PREP: begin
                n_neg           = w_delta[DATA_W];
                w_div_start     = 1'b1;
                w_mul_req.start = 1'b1;
                w_mul_req.a     = MA_W'(r_err);
                w_mul_req.b     = r_gain_p;
                w_mul_req.n     = N_GAIN;
                n_state         = S_P;
            end
            S_P: begin
                if (w_mul_done) begin
                    n_p             = sat_to_data((PW+1)'(w_prod >>> FRAC));
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = MA_W'(r_err);
                    w_mul_req.b     = $signed(MB_W'(r_dt));
                    w_mul_req.n     = N_DT;
                    n_state         = S_EDT;
                end
            end
            S_EDT: begin
                if (w_mul_done) begin
                    n_edt           = w_edt;
                    n_acc           = w_acc_cl;
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = MA_W'(w_acc_cl);
                    w_mul_req.b     = r_gain_i;
                    w_mul_req.n     = N_GAIN;
                    n_state         = S_I;
                end
            end
            S_I: begin
                if (w_mul_done) begin
                    n_i     = sat_to_data((PW+1)'(w_prod >>> FRAC));
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                if (w_div_done) begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = w_rate;
                    w_mul_req.b     = $signed(ALPHA_NEW);
                    w_mul_req.n     = N_ALPHA;
                    n_state         = S_F1;
                end
            end
            S_F1: begin
                if (w_mul_done) begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.accum = 1'b1;
                    w_mul_req.a     = r_filt;
                    w_mul_req.b     = $signed(ALPHA_OLD);
                    w_mul_req.n     = N_ALPHA;
                    n_state         = S_F2;
                end
            end
            S_F2: begin
                if (w_mul_done) begin
                    n_filt          = w_filt;
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = w_filt;
                    w_mul_req.b     = r_gain_d;
                    w_mul_req.n     = N_GAIN;
                    n_state         = S_D;
                end
            end
            S_D: begin
                if (w_mul_done) begin
                    n_d     = sat_to_data(-((PW+1)'(w_prod >>> FRAC)));
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_fin_go) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_clr) begin
                        n_acc   = '0;
                        n_last  = '0;
                        n_filt  = '0;
                        n_drive = '0;
                        n_sat   = 1'b0;
                    end else begin
                        n_drive = w_clamp[DATA_W-1:0];
                        n_sat   = w_hi || w_lo;
                        n_last  = r_meas;
                        if ((w_hi && r_err > 0) || (w_lo && r_err < 0)) begin
                            n_acc = r_acc - (r_edt >>> 1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_P: begin
                    n_gain_p = $signed(i_cfg_data);
                    n_acc    = '0;
                end
                CFG_GAIN_I: begin
                    n_gain_i = $signed(i_cfg_data);
                    n_acc    = '0;
                end
                CFG_GAIN_D: begin
                    n_gain_d = $signed(i_cfg_data);
                    n_acc    = '0;
                end
                CFG_OUT_LIM: begin
                    n_out_lim = i_cfg_data[LIM_W-1:0];
                end
                CFG_INT_LIM: begin
                    n_int_lim = i_cfg_data[LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_out_lim   <= OUT_LIM_RST;
            r_int_lim   <= INT_LIM_RST;
            r_acc       <= '0;
            r_last      <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gain_p    <= n_gain_p;
            r_gain_i    <= n_gain_i;
            r_gain_d    <= n_gain_d;
            r_out_lim   <= n_out_lim;
            r_int_lim   <= n_int_lim;
            r_acc       <= n_acc;
            r_last      <= n_last;
            r_filt      <= n_filt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr   <= n_clr;
        r_meas  <= n_meas;
        r_err   <= n_err;
        r_dt    <= n_dt;
        r_neg   <= n_neg;
        r_edt   <= n_edt;
        r_p     <= n_p;
        r_i     <= n_i;
        r_d     <= n_d;
        r_drive <= n_drive;
        r_sat   <= n_sat;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

    a_int_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDT && w_mul_done) |=>
        (r_acc <= $signed(ACC_W'(r_int_lim)) && r_acc >= -$signed(ACC_W'(r_int_lim))))
        else $error("integral left its clamp after accumulation");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_clr && w_fin_go) |=>
        (r_acc == '0 && r_filt == '0 && r_last == '0 && o_drive == '0 && !o_saturated))
        else $error("clear item did not zero the state and result");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat) |->
        (r_drive == $signed({1'b0, r_out_lim}) || r_drive == -$signed({1'b0, r_out_lim})))
        else $error("saturated result is not at an output limit");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the fixed-point PID controller with filtered derivative.
module tb
    import pidfd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [DATA_W-1:0] drive;
        bit                sat;
    } t_ctl_out;

    localparam logic [CFG_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic OP_STEP = 1'b0;

    class pid_scoreboard;
        t_wide kp, ki, kd, olim, ilim;
        t_wide integ, prev_meas, filt_rate;
        t_ctl_out pending[$];
        int errors;

        function new();
            kp = 0; ki = 0; kd = 0;
            olim = t_wide'(OUT_LIM_RST);
            ilim = t_wide'(INT_LIM_RST);
            integ = 0; prev_meas = 0; filt_rate = 0;
            errors = 0;
        endfunction

        function t_wide clip(t_wide v, int bits);
            t_wide hi;
            hi = (t_wide'(1) <<< (bits - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function void write_reg(logic [CFG_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_GAIN_P: begin kp = t_wide'($signed(data)); integ = 0; end
                CFG_GAIN_I: begin ki = t_wide'($signed(data)); integ = 0; end
                CFG_GAIN_D: begin kd = t_wide'($signed(data)); integ = 0; end
                CFG_OUT_LIM: olim = t_wide'(data[LIM_W-1:0]);
                CFG_INT_LIM: ilim = t_wide'(data[LIM_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic signed [DATA_W-1:0] tgt,
                                logic signed [DATA_W-1:0] meas, logic [TF_W-1:0] st);
            t_wide err, dt, edt, rate, p, i, d, drv, m, anew, aold;
            t_ctl_out e;
            if (op == OP_CLEAR) begin
                integ = 0; prev_meas = 0; filt_rate = 0;
                e.drive = '0; e.sat = 0;
                pending.push_back(e);
                return;
            end
            anew = t_wide'(ALPHA_NEW);
            aold = t_wide'(ALPHA_OLD);
            m = t_wide'(meas);
            dt = t_wide'(st);
            if (dt < t_wide'(DT_MIN)) dt = t_wide'(DT_MIN);
            if (dt > t_wide'(DT_MAX)) dt = t_wide'(DT_MAX);
            err = clip(t_wide'(tgt) - m, DATA_W);
            p = clip((kp * err) >>> FRAC, DATA_W);
            edt = (err * dt) >>> TF_W;
            integ = integ + edt;
            if (integ > ilim) integ = ilim;
            if (integ < -ilim) integ = -ilim;
            i = clip((ki * integ) >>> FRAC, DATA_W);
            rate = clip(((m - prev_meas) <<< TF_W) / dt, 48);
            filt_rate = clip((anew * rate + aold * filt_rate) >>> FRAC, 48);
            d = clip(-((kd * filt_rate) >>> FRAC), DATA_W);
            drv = p + i + d;
            if (drv > olim) drv = olim;
            if (drv < -olim) drv = -olim;
            e.sat = (drv >= olim) || (drv <= -olim);
            if ((drv >= olim && err > 0) || (drv <= -olim && err < 0))
                integ = clip(integ - (edt >>> 1), 48);
            prev_meas = m;
            e.drive = drv[DATA_W-1:0];
            pending.push_back(e);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] drive, logic sat);
            t_ctl_out e;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (drive !== e.drive)
                report($sformatf("drive %h, expected %h", drive, e.drive));
            if (sat !== e.sat)
                report($sformatf("saturated %b, expected %b", sat, e.sat));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic [CFG_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic i_op = 0;
    logic signed [DATA_W-1:0] i_target = '0;
    logic signed [DATA_W-1:0] i_measured = '0;
    logic [TF_W-1:0] i_step_time = '0;
    logic i_out_ready = 0;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_saturated;
    logic signed [DATA_W-1:0] o_drive;

    pid_scoreboard sb = new();
    bit quiet = 0;
    bit started = 0;

    pid_filtered_derivative_antiwindup dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    task write_reg(logic [CFG_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task send_item(logic op, logic [DATA_W-1:0] tgt, logic [DATA_W-1:0] meas,
                   logic [TF_W-1:0] st);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_op = op;
        i_target = tgt;
        i_measured = meas;
        i_step_time = st;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, tgt, meas, st);
        @(negedge i_clk);
    endtask

    task drain();
        @(negedge i_clk);
        i_in_valid = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    function logic [TF_W-1:0] pick_time();
        case ($urandom_range(0, 3))
            0: return TF_W'($urandom());
            1: return TF_W'($urandom_range(0, 200));
            default: return TF_W'($urandom_range(100, 110000));
        endcase
    endfunction

    function logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 0;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function logic [DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0010_0000);
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    initial begin
        forever begin
            int n;
            n = quiet ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (n > 0) begin
                i_out_ready = 0;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready = 1;
            do @(posedge i_clk); while (!(o_out_valid && started));
            sb.check_result(o_drive, o_saturated);
        end
    end

    initial begin
        logic signed [DATA_W-1:0] base;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        started = 1;

        send_item(OP_STEP, 32'h0001_0000, 32'h0000_8000, 20'd0);
        drain();
        write_reg(CFG_GAIN_P, 32'h0002_0000);
        write_reg(CFG_GAIN_I, 32'h0001_0000);
        write_reg(CFG_GAIN_D, 32'h0000_4000);
        send_item(OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 20'hfffff);
        send_item(OP_STEP, 32'h8000_0000, 32'h7fff_ffff, 20'd104);
        send_item(OP_STEP, 32'h0000_0000, 32'h0000_0000, 20'd105);
        send_item(OP_STEP, 32'h0003_0000, 32'h0001_0000, 20'd104858);
        send_item(OP_STEP, 32'h0003_0000, 32'h0001_0000, 20'd104859);
        send_item(OP_CLEAR, 32'h1234_5678, 32'h8765_4321, 20'h5a5a5);
        send_item(OP_STEP, 32'hffff_0000, 32'h0002_0000, 20'd1000);
        drain();
        write_reg(CFG_GAIN_P, 32'h7fff_ffff);
        write_reg(CFG_GAIN_I, 32'h8000_0000);
        write_reg(CFG_GAIN_D, 32'h7fff_ffff);
        write_reg(CFG_OUT_LIM, 32'h0000_0000);
        write_reg(CFG_INT_LIM, 32'h0000_0000);
        write_reg(CFG_SPARE_LO, 32'hffff_ffff);
        write_reg(CFG_SPARE_HI, 32'h0000_0001);
        send_item(OP_STEP, 32'h0100_0000, 32'h0000_0000, 20'd5000);
        send_item(OP_STEP, 32'h8000_0000, 32'h7fff_ffff, 20'd105);
        drain();
        write_reg(CFG_OUT_LIM, 32'hffff_ffff);
        write_reg(CFG_INT_LIM, 32'h7fff_ffff);
        send_item(OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 20'd104858);
        send_item(OP_STEP, 32'h8000_0000, 32'h7fff_ffff, 20'd104858);
        drain();
        write_reg(CFG_GAIN_P, 32'h0004_0000);
        write_reg(CFG_GAIN_I, 32'h0010_0000);
        write_reg(CFG_GAIN_D, 32'h0000_0000);
        write_reg(CFG_OUT_LIM, 32'h0002_0000);
        write_reg(CFG_INT_LIM, 32'h0001_0000);
        repeat (6) send_item(OP_STEP, 32'h0005_0000, 32'h0000_0000, 20'd50000);
        repeat (3) send_item(OP_STEP, 32'hfffb_0000, 32'h0000_0000, 20'd50000);

        for (int ph = 0; ph < 12; ph++) begin
            drain();
            quiet = (ph % 4 == 3);
            if (ph == 5) begin
                write_reg(CFG_GAIN_P, 32'h8000_0000);
                write_reg(CFG_GAIN_I, 32'h7fff_ffff);
                write_reg(CFG_GAIN_D, 32'h8000_0000);
                write_reg(CFG_OUT_LIM, 32'h7fff_ffff);
                write_reg(CFG_INT_LIM, 32'h7fff_ffff);
            end else begin
                write_reg(CFG_GAIN_P, pick_gain());
                write_reg(CFG_GAIN_I, pick_gain());
                write_reg(CFG_GAIN_D, pick_gain());
                write_reg(CFG_OUT_LIM, pick_limit());
                write_reg(CFG_INT_LIM, pick_limit());
            end
            base = pick_value();
            for (int k = 0; k < 70; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_CLEAR, $urandom(), $urandom(), TF_W'($urandom()));
                else if ($urandom_range(0, 2) == 0)
                    send_item(OP_STEP, pick_value(), pick_value(), pick_time());
                else
                    send_item(OP_STEP, base, base + $urandom_range(0, 32'h0004_0000)
                              - 32'h0002_0000, pick_time());
            end
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
